### src/bba_pkg.sv
// Shared types and constants of the bitmap block allocator.
// Used by bitmap_block_allocator and bba_checker; depends on nothing.
package bba_pkg;

    localparam int unsigned BLOCK_BYTES_DEF = 16;
    localparam int unsigned NUM_BLOCKS_DEF  = 256;
    localparam int unsigned WORD_BITS       = 16;
    localparam logic [31:0] HEAP_BASE_RESET = 32'h2000_1000;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_SPACE   = 3'd1;
    localparam logic [2:0] ST_NULL       = 3'd2;
    localparam logic [2:0] ST_BOUNDS     = 3'd3;
    localparam logic [2:0] ST_MISALIGNED = 3'd4;

    typedef struct packed {
        logic        op;
        logic [15:0] request_bytes;
        logic [31:0] free_address;
    } cmd_t;

    typedef struct packed {
        logic [31:0] block_address;
        logic [2:0]  status;
        logic [8:0]  blocks_changed;
    } result_t;

endpackage

### src/bitmap_block_allocator.sv
// Top level of the first-fit bitmap block allocator.
// Depends on bba_pkg and bba_div; keeps the used map in a word-wide memory.
//
//   channel   signals                         transfer
//   command   start, busy, cmd                beat taken when start && !busy
//   result    done, result                    one-cycle strobe, no back-pressure
//   config    cfg_valid, cfg_ready, cfg_data  beat taken when cfg_valid && cfg_ready
//
// An accepted command passes the block-size divider; an allocation then scans the 16-block
// map words up to the hit, marks each word of the range, and forms address, result and
// strobe. A free clears the used run word by word; a misaligned free ends after the divider,
// a failed scan after the last map word, and a null, out-of-bounds or oversized command at once.
// Reset clears the map at once through per-word valid bits; no clearing pass is run.
// The result is a one-cycle strobe; busy is low in that cycle, so a new command may follow.
module bitmap_block_allocator #(
    parameter int unsigned BLOCK_BYTES = bba_pkg::BLOCK_BYTES_DEF,
    parameter int unsigned NUM_BLOCKS  = bba_pkg::NUM_BLOCKS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  bba_pkg::cmd_t    cmd,
    output logic             done,
    output bba_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [31:0]      cfg_data
);

    localparam int unsigned WB        = bba_pkg::WORD_BITS;
    localparam int unsigned WB_W      = $clog2(WB);
    localparam int unsigned NUM_WORDS = (NUM_BLOCKS + WB - 1) / WB;
    localparam int unsigned WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int unsigned BI_W      = WADDR_W + WB_W;
    localparam int unsigned CNT_W     = $clog2(NUM_BLOCKS + 1);
    localparam int unsigned DIV_W     = $clog2((NUM_BLOCKS + 1) * BLOCK_BYTES);
    localparam int unsigned PROD_W    = BI_W + $clog2(BLOCK_BYTES + 1);
    localparam logic [31:0] HEAP_BYTES = 32'(NUM_BLOCKS * BLOCK_BYTES);
    localparam logic [WADDR_W-1:0] LAST_W = WADDR_W'(NUM_WORDS - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_SCAN, S_MARK, S_MUL, S_ADDR, S_FREE, S_FIN
    } state_t;

    state_t              state_reg;
    logic                busy_reg;
    logic                done_reg;
    bba_pkg::result_t    result_reg;
    logic                op_reg;
    logic [31:0]         heap_base_reg;
    logic [CNT_W-1:0]    need_reg;
    logic [CNT_W-1:0]    carry_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [WADDR_W-1:0]  word_ptr_reg;
    logic [WB_W-1:0]     bitpos_reg;
    logic [BI_W-1:0]     start_reg;
    logic [BI_W-1:0]     end_reg;
    logic [PROD_W-1:0]   prod_reg;

    // used map memory with per-word valid bits
    logic [WB-1:0]       mem [NUM_WORDS];
    logic                row_valid_reg [NUM_WORDS];
    logic [WB-1:0]       rd_data_reg;
    logic                rd_valid_reg;
    logic                rd_en;
    logic [WADDR_W-1:0]  rd_addr;
    logic                wr_en;
    logic [WADDR_W-1:0]  wr_addr;
    logic [WB-1:0]       wr_data;

    // divider
    logic                div_start;
    logic [DIV_W-1:0]    div_numer;
    logic                div_done;
    logic [CNT_W-1:0]    div_quot;
    logic [DIV_W-1:0]    div_rem;
    logic [BI_W-1:0]     div_blk;

    // word datapath
    logic [WB-1:0]       word_q;
    logic [WB-1:0]       inrange;
    logic [WB-1:0]       used_w;
    logic [WB-1:0]       free_w;
    logic [CNT_W-1:0]    need_scan;
    logic                hit;
    logic [WB_W-1:0]     hit_pos;
    logic [CNT_W-1:0]    next_carry;
    logic [BI_W-1:0]     hit_end;
    logic [BI_W-1:0]     hit_start;
    logic [BI_W:0]       start_wide;
    logic [WB-1:0]       mark_mask;
    logic [WB-1:0]       clr_mask;
    logic [WB_W:0]       ones_run;
    logic                free_cont;
    logic [CNT_W-1:0]    cnt_next;
    logic [31:0]         offset;
    logic                accept;

    assign accept    = start && !busy_reg;
    assign offset    = cmd.free_address - heap_base_reg;
    assign div_blk   = BI_W'(div_quot);
    assign need_scan = (need_reg == '0) ? CNT_W'(1) : need_reg;

    bba_div #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .NUM_BLOCKS  (NUM_BLOCKS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    always_comb
    begin
        div_start = 1'b0;
        div_numer = DIV_W'(offset);
        if (accept)
        begin
            if (cmd.op == bba_pkg::OP_ALLOC)
            begin
                div_start = (32'(cmd.request_bytes) <= HEAP_BYTES);
                div_numer = DIV_W'(32'(cmd.request_bytes) + 32'(BLOCK_BYTES - 1));
            end
            else
            begin
                div_start = (cmd.free_address != '0) && (offset < HEAP_BYTES);
            end
        end
    end

    // current word, with blocks past the heap end flagged
    assign word_q = rd_valid_reg ? rd_data_reg : '0;

    always_comb
    begin
        for (int j = 0; j < WB; j++)
        begin
            inrange[j] = (32'({word_ptr_reg, WB_W'(j)}) < 32'(NUM_BLOCKS));
        end
    end

    assign used_w = word_q | ~inrange;
    assign free_w = word_q & inrange;

    // first-fit scan of one word: free run length ending at each bit
    always_comb
    begin
        logic [CNT_W-1:0] run_len [WB];
        logic             seen;
        int               last_pos;
        hit     = 1'b0;
        hit_pos = '0;
        for (int j = 0; j < WB; j++)
        begin
            seen     = 1'b0;
            last_pos = 0;
            for (int k = 0; k < WB; k++)
            begin
                if (k <= j && used_w[k])
                begin
                    seen     = 1'b1;
                    last_pos = k;
                end
            end
            if (seen)
            begin
                run_len[j] = CNT_W'(j - last_pos);
            end
            else
            begin
                run_len[j] = carry_reg + CNT_W'(j + 1);
            end
        end
        for (int j = WB - 1; j >= 0; j--)
        begin
            if (!used_w[j] && run_len[j] >= need_scan)
            begin
                hit     = 1'b1;
                hit_pos = WB_W'(j);
            end
        end
        next_carry = run_len[WB-1];
    end

    assign hit_end    = {word_ptr_reg, hit_pos};
    assign start_wide = (BI_W + 1)'(hit_end) + (BI_W + 1)'(1) - (BI_W + 1)'(need_scan);
    assign hit_start  = BI_W'(start_wide);

    // set mask for the marked range within the current word
    always_comb
    begin
        logic [WB_W-1:0] lo;
        logic [WB_W-1:0] hi;
        lo = (word_ptr_reg == start_reg[BI_W-1:WB_W]) ? start_reg[WB_W-1:0] : '0;
        hi = (word_ptr_reg == end_reg[BI_W-1:WB_W]) ? end_reg[WB_W-1:0] : '1;
        for (int j = 0; j < WB; j++)
        begin
            mark_mask[j] = (WB_W'(j) >= lo) && (WB_W'(j) <= hi);
        end
    end

    // free: length of the used run starting at bitpos
    always_comb
    begin
        logic [WB-1:0] shifted;
        shifted  = free_w >> bitpos_reg;
        ones_run = (WB_W + 1)'(WB);
        for (int k = WB - 1; k >= 0; k--)
        begin
            if (!shifted[k])
            begin
                ones_run = (WB_W + 1)'(k);
            end
        end
        for (int j = 0; j < WB; j++)
        begin
            clr_mask[j] = ((WB_W + 1)'(j) >= (WB_W + 1)'(bitpos_reg))
                && ((WB_W + 1)'(j) < (WB_W + 1)'(bitpos_reg) + ones_run);
        end
    end

    assign free_cont = ((WB_W + 1)'(bitpos_reg) + ones_run == (WB_W + 1)'(WB))
        && (word_ptr_reg != LAST_W);
    assign cnt_next  = cnt_reg + CNT_W'(ones_run);

    // memory port control
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = word_ptr_reg + 1'b1;
        wr_en   = 1'b0;
        wr_addr = word_ptr_reg;
        wr_data = word_q;
        unique case (state_reg)
            S_DIV:
            begin
                if (div_done)
                begin
                    if (op_reg == bba_pkg::OP_ALLOC)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                    end
                    else
                    begin
                        rd_en   = (div_rem == '0);
                        rd_addr = div_blk[BI_W-1:WB_W];
                    end
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    rd_en   = 1'b1;
                    rd_addr = hit_start[BI_W-1:WB_W];
                end
                else
                begin
                    rd_en = (word_ptr_reg != LAST_W);
                end
            end
            S_MARK:
            begin
                wr_en   = 1'b1;
                wr_data = word_q | mark_mask;
                rd_en   = (word_ptr_reg != end_reg[BI_W-1:WB_W]);
            end
            S_FREE:
            begin
                wr_en   = 1'b1;
                wr_data = word_q & ~clr_mask;
                rd_en   = free_cont;
            end
            S_IDLE, S_MUL, S_ADDR, S_FIN:
            begin
                rd_en = 1'b0;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                row_valid_reg[i] <= 1'b0;
            end
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg <= bba_pkg::HEAP_BASE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            heap_base_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        busy_reg <= 1'b1;
                        op_reg   <= cmd.op;
                        if (div_start)
                        begin
                            state_reg <= S_DIV;
                        end
                        else
                        begin
                            state_reg <= S_FIN;
                            result_reg.block_address  <= '0;
                            result_reg.blocks_changed <= '0;
                            if (cmd.op == bba_pkg::OP_ALLOC)
                            begin
                                result_reg.status <= bba_pkg::ST_NO_SPACE;
                            end
                            else if (cmd.free_address == '0)
                            begin
                                result_reg.status <= bba_pkg::ST_NULL;
                            end
                            else
                            begin
                                result_reg.status <= bba_pkg::ST_BOUNDS;
                            end
                        end
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        if (op_reg == bba_pkg::OP_ALLOC)
                        begin
                            need_reg     <= div_quot;
                            carry_reg    <= '0;
                            word_ptr_reg <= '0;
                            state_reg    <= S_SCAN;
                        end
                        else if (div_rem != '0)
                        begin
                            result_reg.block_address  <= '0;
                            result_reg.status         <= bba_pkg::ST_MISALIGNED;
                            result_reg.blocks_changed <= '0;
                            state_reg                 <= S_FIN;
                        end
                        else
                        begin
                            word_ptr_reg <= div_blk[BI_W-1:WB_W];
                            bitpos_reg   <= div_blk[WB_W-1:0];
                            cnt_reg      <= '0;
                            state_reg    <= S_FREE;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (hit)
                    begin
                        start_reg <= hit_start;
                        end_reg   <= hit_end;
                        if (need_reg == '0)
                        begin
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            word_ptr_reg <= hit_start[BI_W-1:WB_W];
                            state_reg    <= S_MARK;
                        end
                    end
                    else if (word_ptr_reg == LAST_W)
                    begin
                        result_reg.block_address  <= '0;
                        result_reg.status         <= bba_pkg::ST_NO_SPACE;
                        result_reg.blocks_changed <= '0;
                        state_reg                 <= S_FIN;
                    end
                    else
                    begin
                        carry_reg    <= next_carry;
                        word_ptr_reg <= word_ptr_reg + 1'b1;
                    end
                end
                S_MARK:
                begin
                    if (word_ptr_reg == end_reg[BI_W-1:WB_W])
                    begin
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        word_ptr_reg <= word_ptr_reg + 1'b1;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= PROD_W'(start_reg) * PROD_W'(BLOCK_BYTES);
                    state_reg <= S_ADDR;
                end
                S_ADDR:
                begin
                    result_reg.block_address  <= heap_base_reg + 32'(prod_reg);
                    result_reg.status         <= bba_pkg::ST_OK;
                    result_reg.blocks_changed <= 9'(need_reg);
                    state_reg                 <= S_FIN;
                end
                S_FREE:
                begin
                    if (free_cont)
                    begin
                        // run fills the word to its top: continue in the next word
                        word_ptr_reg <= word_ptr_reg + 1'b1;
                        bitpos_reg   <= '0;
                        cnt_reg      <= cnt_next;
                    end
                    else
                    begin
                        result_reg.block_address  <= '0;
                        result_reg.status         <= bba_pkg::ST_OK;
                        result_reg.blocks_changed <= 9'(cnt_next);
                        state_reg                 <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    done_reg  <= 1'b1;
                    busy_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = !busy_reg;

endmodule

### src/bba_div.sv
// Divider by the constant block size through a reciprocal multiply.
// Depends on nothing outside this file; instantiated by bitmap_block_allocator.
module bba_div #(
    parameter int unsigned BLOCK_BYTES = 16,
    parameter int unsigned NUM_BLOCKS  = 256
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              start,
    input  logic [$clog2((NUM_BLOCKS + 1) * BLOCK_BYTES)-1:0] numer,
    output logic                                              done,
    output logic [$clog2(NUM_BLOCKS + 1)-1:0]                 quot,
    output logic [$clog2((NUM_BLOCKS + 1) * BLOCK_BYTES)-1:0] rem
);

    localparam int unsigned DIV_W  = $clog2((NUM_BLOCKS + 1) * BLOCK_BYTES);
    localparam int unsigned QW     = $clog2(NUM_BLOCKS + 1);
    localparam int unsigned SH     = DIV_W + $clog2(BLOCK_BYTES);
    localparam int unsigned RCP_W  = DIV_W + 2;
    localparam int unsigned PROD_W = DIV_W + RCP_W;
    // ceil(2^SH / BLOCK_BYTES) gives the exact quotient for every DIV_W-bit numerator
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((64'd1 << SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES));

    logic [DIV_W-1:0]  num_reg;
    logic [QW-1:0]     quot_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic              stage1_reg;
    logic              stage2_reg;
    logic              done_reg;
    logic [PROD_W-1:0] prod;
    logic [DIV_W-1:0]  back;

    assign prod = PROD_W'(num_reg) * PROD_W'(RECIP);
    assign back = DIV_W'(quot_reg) * DIV_W'(BLOCK_BYTES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage1_reg <= 1'b0;
            stage2_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            stage1_reg <= start;
            stage2_reg <= stage1_reg;
            done_reg   <= stage2_reg;
            if (start)
            begin
                num_reg <= numer;
            end
            if (stage1_reg)
            begin
                quot_reg <= QW'(prod >> SH);
            end
            if (stage2_reg)
            begin
                rem_reg <= num_reg - back;
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

### src/bba_checker.sv
// Port-level checks for the bitmap block allocator, bound to the top level.
// Depends on bba_pkg and bitmap_block_allocator.
module bba_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input bba_pkg::result_t result
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == bba_pkg::ST_OK || result.status == bba_pkg::ST_NO_SPACE
            || result.status == bba_pkg::ST_NULL || result.status == bba_pkg::ST_BOUNDS
            || result.status == bba_pkg::ST_MISALIGNED))
        else $error("illegal status code");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != bba_pkg::ST_OK
            |-> result.block_address == '0 && result.blocks_changed == '0)
        else $error("failed request reports address or count");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
